### hw/rtl/ctdf_pkg.sv
// Shared types, constants and control structs for the child table block.
package ctdf_pkg;

    localparam int HISTORY_DEPTH_DEF  = 8;
    localparam int CHILD_CAPACITY_DEF = 8;

    localparam int ADDR_W   = 16;
    localparam int SEQ_W    = 8;
    localparam int CODE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 2'd3;

    // register index is paddr bit 2
    localparam logic REG_ACK_CODE    = 1'b0;
    localparam logic REG_REMOVE_CODE = 1'b1;

    localparam logic [CODE_W-1:0] ACK_CODE_RST    = 8'd1;
    localparam logic [CODE_W-1:0] REMOVE_CODE_RST = 8'd2;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] node_address;
        logic [SEQ_W-1:0]  sequence_number;
        logic [CODE_W-1:0] msg_code;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  child_count;
    } result_t;

    typedef struct packed {
        logic                load_item;
        logic                idx_clr;
        logic                idx_inc;
        logic                h_rd;
        logic                h_ins;
        logic                h_upd;
        logic                c_rd;
        logic                c_add;
        logic                sh_rd;
        logic                sh_wr;
        logic                c_dec;
        logic                st_en;
        logic [STATUS_W-1:0] st_code;
        logic                out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_timeout;
        logic is_ack;
        logic is_remove;
        logic h_more;
        logic h_addr_hit;
        logic h_seq_hit;
        logic c_more;
        logic c_hit;
        logic c_full;
        logic sh_more;
        logic out_free;
    } dp_stat_t;

endpackage

### hw/rtl/ctdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ctdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/ctdf_dp.sv
// Datapath: item latch, history and child RAMs, counters, result register.
module ctdf_dp
    import ctdf_pkg::*;
#(
    parameter int HISTORY_DEPTH  = HISTORY_DEPTH_DEF,
    parameter int CHILD_CAPACITY = CHILD_CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  item_t             item,
    input  logic [CODE_W-1:0] ack_code,
    input  logic [CODE_W-1:0] remove_code,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    localparam int HAW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CAW  = (CHILD_CAPACITY > 1) ? $clog2(CHILD_CAPACITY) : 1;
    localparam int HUW  = $clog2(HISTORY_DEPTH + 1);
    localparam int CHW  = $clog2(CHILD_CAPACITY + 1);
    localparam int MAXD = (HISTORY_DEPTH > CHILD_CAPACITY) ? HISTORY_DEPTH : CHILD_CAPACITY;
    localparam int IW   = $clog2(MAXD + 1);
    localparam int HW   = ADDR_W + SEQ_W;

    item_t               item_reg;
    logic [IW-1:0]       idx_reg, idx_next, idx_p1;
    logic [HUW-1:0]      used_reg, used_next;
    logic [HAW-1:0]      oldest_reg, oldest_next;
    logic [CHW-1:0]      held_reg, held_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                res_valid_reg, res_valid_next;
    result_t             res_reg, res_next;

    logic                h_full;
    logic [HAW-1:0]      h_ins_slot;
    logic                h_wr_en;
    logic [HAW-1:0]      h_wr_addr;
    logic [HW-1:0]       h_rdata;
    logic                c_wr_en;
    logic [CAW-1:0]      c_wr_addr;
    logic [ADDR_W-1:0]   c_wr_data;
    logic [CAW-1:0]      c_rd_addr;
    logic [ADDR_W-1:0]   c_rdata;
    logic [7:0]          held_ext;

    assign idx_p1     = idx_reg + 1'b1;
    assign h_full     = (used_reg == HUW'(HISTORY_DEPTH));
    assign h_ins_slot = h_full ? oldest_reg : used_reg[HAW-1:0];
    assign h_wr_en    = cmd.h_ins | cmd.h_upd;
    assign h_wr_addr  = cmd.h_upd ? idx_reg[HAW-1:0] : h_ins_slot;

    ctdf_ram #(
        .WIDTH (HW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data ({item_reg.node_address, item_reg.sequence_number}),
        .rd_en   (cmd.h_rd),
        .rd_addr (idx_reg[HAW-1:0]),
        .rd_data (h_rdata)
    );

    // add appends at the tail; compaction copies entry idx+1 down to idx
    assign c_wr_en   = cmd.c_add | cmd.sh_wr;
    assign c_wr_addr = cmd.c_add ? held_reg[CAW-1:0] : idx_reg[CAW-1:0];
    assign c_wr_data = cmd.c_add ? item_reg.node_address : c_rdata;
    assign c_rd_addr = cmd.sh_rd ? idx_p1[CAW-1:0] : idx_reg[CAW-1:0];

    ctdf_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (CHILD_CAPACITY)
    ) u_child_ram (
        .clk     (clk),
        .wr_en   (c_wr_en),
        .wr_addr (c_wr_addr),
        .wr_data (c_wr_data),
        .rd_en   (cmd.c_rd | cmd.sh_rd),
        .rd_addr (c_rd_addr),
        .rd_data (c_rdata)
    );

    always_comb
    begin
        stat.is_timeout = item_reg.mode;
        stat.is_ack     = (item_reg.msg_code == ack_code);
        stat.is_remove  = (item_reg.msg_code == remove_code);
        stat.h_more     = (idx_reg < IW'(used_reg));
        stat.h_addr_hit = (h_rdata[HW-1:SEQ_W] == item_reg.node_address);
        stat.h_seq_hit  = (h_rdata[SEQ_W-1:0] == item_reg.sequence_number);
        stat.c_more     = (idx_reg < IW'(held_reg));
        stat.c_hit      = (c_rdata == item_reg.node_address);
        stat.c_full     = (held_reg == CHW'(CHILD_CAPACITY));
        stat.sh_more    = (idx_p1 < IW'(held_reg));
        stat.out_free   = !res_valid_reg || result_ready;
    end

    assign held_ext = 8'(held_reg);

    always_comb
    begin
        idx_next       = idx_reg;
        used_next      = used_reg;
        oldest_next    = oldest_reg;
        held_next      = held_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_p1;
        end

        if (cmd.h_ins)
        begin
            if (!h_full)
            begin
                used_next = used_reg + 1'b1;
            end
            else
            begin
                oldest_next = (oldest_reg == HAW'(HISTORY_DEPTH - 1)) ? '0
                                                                     : oldest_reg + 1'b1;
            end
        end

        if (cmd.c_add)
        begin
            held_next = held_reg + 1'b1;
        end
        else if (cmd.c_dec)
        begin
            held_next = held_reg - 1'b1;
        end

        if (cmd.st_en)
        begin
            status_next = cmd.st_code;
        end

        if (cmd.out_load)
        begin
            res_valid_next     = 1'b1;
            res_next.status      = status_reg;
            res_next.child_count = held_ext[COUNT_W-1:0];
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            used_reg      <= '0;
            oldest_reg    <= '0;
            held_reg      <= '0;
            status_reg    <= ST_NONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            used_reg      <= used_next;
            oldest_reg    <= oldest_next;
            held_reg      <= held_next;
            status_reg    <= status_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CHW'(CHILD_CAPACITY))
        else $error("child count beyond capacity");

    // replacement pointer only moves once the history has filled
    a_oldest_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !h_full |-> oldest_reg == '0)
        else $error("replacement slot moved before history full");

    a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.c_add |-> !stat.c_full)
        else $error("child add with full table");

endmodule

### hw/rtl/ctdf_ctrl.sv
// Controller: sequences history search, child search/add and compaction.
module ctdf_ctrl
    import ctdf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_H_RD   = 4'd1;
    localparam logic [3:0] S_H_CMP  = 4'd2;
    localparam logic [3:0] S_CODE   = 4'd3;
    localparam logic [3:0] S_C_RD   = 4'd4;
    localparam logic [3:0] S_C_CMP  = 4'd5;
    localparam logic [3:0] S_SH_RD  = 4'd6;
    localparam logic [3:0] S_SH_WR  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       op_add_reg, op_add_next;

    always_comb
    begin
        state_next  = state_reg;
        op_add_next = op_add_reg;
        cmd         = '0;
        cmd.st_code = ST_NONE;
        item_ready  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = S_H_RD;
                end
            end
            S_H_RD:
            begin
                // timeout skips the history entirely
                if (stat.is_timeout)
                begin
                    op_add_next = 1'b0;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_C_RD;
                end
                else if (stat.h_more)
                begin
                    cmd.h_rd   = 1'b1;
                    state_next = S_H_CMP;
                end
                else
                begin
                    cmd.h_ins  = 1'b1;
                    state_next = S_CODE;
                end
            end
            S_H_CMP:
            begin
                if (stat.h_addr_hit)
                begin
                    if (stat.h_seq_hit)
                    begin
                        cmd.st_en   = 1'b1;
                        cmd.st_code = ST_DUP;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.h_upd  = 1'b1;
                        state_next = S_CODE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_H_RD;
                end
            end
            S_CODE:
            begin
                cmd.idx_clr = 1'b1;
                // ack wins when both codes match
                if (stat.is_ack && !stat.c_full)
                begin
                    op_add_next = 1'b1;
                    state_next  = S_C_RD;
                end
                else if (!stat.is_ack && stat.is_remove)
                begin
                    op_add_next = 1'b0;
                    state_next  = S_C_RD;
                end
                else
                begin
                    cmd.st_en   = 1'b1;
                    cmd.st_code = ST_NONE;
                    state_next  = S_DONE;
                end
            end
            S_C_RD:
            begin
                if (stat.c_more)
                begin
                    cmd.c_rd   = 1'b1;
                    state_next = S_C_CMP;
                end
                else
                begin
                    cmd.st_en = 1'b1;
                    if (op_add_reg)
                    begin
                        cmd.c_add   = 1'b1;
                        cmd.st_code = ST_ADDED;
                    end
                    else
                    begin
                        cmd.st_code = ST_NONE;
                    end
                    state_next = S_DONE;
                end
            end
            S_C_CMP:
            begin
                if (stat.c_hit)
                begin
                    if (op_add_reg)
                    begin
                        cmd.st_en   = 1'b1;
                        cmd.st_code = ST_NONE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_C_RD;
                end
            end
            S_SH_RD:
            begin
                if (stat.sh_more)
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SH_WR;
                end
                else
                begin
                    cmd.c_dec   = 1'b1;
                    cmd.st_en   = 1'b1;
                    cmd.st_code = ST_REMOVED;
                    state_next  = S_DONE;
                end
            end
            S_SH_WR:
            begin
                cmd.sh_wr   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_SH_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_add_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_add_reg <= op_add_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> state_reg == S_H_RD)
        else $error("accepted item did not start history search");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an untaken result");

endmodule

### hw/rtl/child_table_with_duplicate_filter_top.sv
// Top level: configuration registers, controller and datapath.
// Child table with per-sender duplicate filter. Each item (received message or
// delivery timeout) yields exactly one result: a status and the child count.
// The block works on one item at a time; the result sits in an output register
// so the next item is taken while it waits. Both tables are RAMs with separate
// read and write ports, scanned one entry at a time (read, then compare); each
// history entry compared, child compared or child shifted down adds a read step
// and a compare or write step, and the worst case is a new sender removing the
// first of a full child table. Timeouts skip the history scan. Config registers
// sit at byte offsets 0 (ack code) and 4 (remove code) and should be written
// while idle.
module child_table_with_duplicate_filter_top
    import ctdf_pkg::*;
#(
    parameter int HISTORY_DEPTH  = HISTORY_DEPTH_DEF,
    parameter int CHILD_CAPACITY = CHILD_CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CODE_W-1:0] ack_code_reg, ack_code_next;
    logic [CODE_W-1:0] remove_code_reg, remove_code_next;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        ack_code_next    = ack_code_reg;
        remove_code_next = remove_code_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ACK_CODE:    ack_code_next    = pwdata[CODE_W-1:0];
                REG_REMOVE_CODE: remove_code_next = pwdata[CODE_W-1:0];
                default:         ack_code_next    = ack_code_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ACK_CODE:    prdata = PDATA_W'(ack_code_reg);
            REG_REMOVE_CODE: prdata = PDATA_W'(remove_code_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_code_reg    <= ACK_CODE_RST;
            remove_code_reg <= REMOVE_CODE_RST;
        end
        else
        begin
            ack_code_reg    <= ack_code_next;
            remove_code_reg <= remove_code_next;
        end
    end

    ctdf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    ctdf_dp #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .CHILD_CAPACITY (CHILD_CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ack_code     (ack_code_reg),
        .remove_code  (remove_code_reg),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### bench/child_table_with_duplicate_filter_checker.sv
// Checker: tracks child table and sender history, compares every result with its prediction.
`timescale 1ns / 100ps

module child_table_with_duplicate_filter_checker
    import ctdf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  item_t              item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    output int                 mismatch_count,
    output int                 outstanding
);

    logic [ADDR_W-1:0] sender_addr [HISTORY_DEPTH_DEF];
    logic [SEQ_W-1:0]  sender_seq [HISTORY_DEPTH_DEF];
    int                senders_known;
    int                next_evict;
    logic [ADDR_W-1:0] children [CHILD_CAPACITY_DEF];
    int                child_total;
    logic [CODE_W-1:0] ack_code_cfg;
    logic [CODE_W-1:0] remove_code_cfg;
    result_t           pending_outcomes [$];
    result_t           oldest_outcome;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic int child_slot(input logic [ADDR_W-1:0] addr);
        for (int i = 0; i < child_total; i++)
            if (children[i] == addr)
                return i;
        return -1;
    endfunction

    // removal keeps the order of the remaining children
    function automatic logic [STATUS_W-1:0] drop_child_entry(input logic [ADDR_W-1:0] addr);
        int pos;
        pos = child_slot(addr);
        if (pos < 0)
            return ST_NONE;
        for (int i = pos; i + 1 < child_total; i++)
            children[i] = children[i + 1];
        child_total--;
        return ST_REMOVED;
    endfunction

    // true when the sender's last sequence number repeats; updates the history otherwise
    function automatic bit is_repeat(input logic [ADDR_W-1:0] addr,
                                     input logic [SEQ_W-1:0] seq);
        for (int i = 0; i < senders_known; i++) begin
            if (sender_addr[i] == addr) begin
                if (sender_seq[i] == seq)
                    return 1'b1;
                sender_seq[i] = seq;
                return 1'b0;
            end
        end
        if (senders_known < HISTORY_DEPTH_DEF) begin
            sender_addr[senders_known] = addr;
            sender_seq[senders_known] = seq;
            senders_known++;
        end
        else begin
            sender_addr[next_evict] = addr;
            sender_seq[next_evict] = seq;
            next_evict = (next_evict + 1) % HISTORY_DEPTH_DEF;
        end
        return 1'b0;
    endfunction

    function automatic result_t table_outcome(input item_t it);
        result_t             outcome;
        logic [STATUS_W-1:0] status;
        status = ST_NONE;
        if (it.mode)
            status = drop_child_entry(it.node_address);
        else if (is_repeat(it.node_address, it.sequence_number))
            status = ST_DUP;
        else if (it.msg_code == ack_code_cfg) begin
            if (child_total < CHILD_CAPACITY_DEF && child_slot(it.node_address) < 0) begin
                children[child_total] = it.node_address;
                child_total++;
                status = ST_ADDED;
            end
        end
        else if (it.msg_code == remove_code_cfg)
            status = drop_child_entry(it.node_address);
        outcome.status = status;
        outcome.child_count = COUNT_W'(child_total);
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            senders_known = 0;
            next_evict = 0;
            child_total = 0;
            ack_code_cfg = ACK_CODE_RST;
            remove_code_cfg = REMOVE_CODE_RST;
            pending_outcomes.delete();
            outstanding = 0;
        end
        else begin
            // results first: an item taken at this edge cannot have its result out yet
            if (result_valid && result_ready) begin
                if (pending_outcomes.size() == 0)
                    report_mismatch("result with no item pending", result.status, -1);
                else begin
                    oldest_outcome = pending_outcomes.pop_front();
                    if (result.status !== oldest_outcome.status)
                        report_mismatch("status", result.status, oldest_outcome.status);
                    if (result.child_count !== oldest_outcome.child_count)
                        report_mismatch("child_count", result.child_count,
                                        oldest_outcome.child_count);
                end
            end
            if (item_valid && item_ready)
                pending_outcomes.push_back(table_outcome(item));
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_REMOVE_CODE)
                    remove_code_cfg = pwdata[CODE_W-1:0];
                else
                    ack_code_cfg = pwdata[CODE_W-1:0];
            end
            outstanding = pending_outcomes.size();
        end
    end

endmodule

### bench/child_table_with_duplicate_filter_top_test.sv
// Testbench top: clock, reset, register writes, item traffic and final verdict.
`timescale 1ns / 100ps

module child_table_with_duplicate_filter_top_test;
    import ctdf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_STALL   = 300;
    localparam int POOL_SIZE    = 12;
    localparam int PHASE_ITEMS  = 295;
    localparam int PHASES       = 6;
    localparam int SETTLE_TIME  = 60;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    item_t              item = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    result_t            result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int stall_requests = 0;
    int stalls_served = 0;
    int stall_left = 0;

    logic [CODE_W-1:0] ack_now;
    logic [CODE_W-1:0] remove_now;
    logic [ADDR_W-1:0] node_pool [POOL_SIZE];
    logic [SEQ_W-1:0]  last_seq [POOL_SIZE];

    int ack_plan [PHASES]    = '{1, 0, 255, 7, 200, 1};
    int remove_plan [PHASES] = '{2, 255, 0, 7, 13, 2};

    child_table_with_duplicate_filter_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    child_table_with_duplicate_filter_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random backpressure, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (stall_requests != stalls_served) begin
            stalls_served++;
            stall_left = LONG_STALL;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // all tasks are entered and left at a falling edge
    task automatic write_register(input logic idx, input logic [CODE_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom()), value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_codes(input logic [CODE_W-1:0] ack, input logic [CODE_W-1:0] rem);
        write_register(REG_ACK_CODE, ack);
        write_register(REG_REMOVE_CODE, rem);
        ack_now = ack;
        remove_now = rem;
    endtask

    task automatic send_item(input item_t it);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic mode, input logic [ADDR_W-1:0] addr,
                               input logic [SEQ_W-1:0] seq, input logic [CODE_W-1:0] code);
        item_t it;
        it.mode = mode;
        it.node_address = addr;
        it.sequence_number = seq;
        it.msg_code = code;
        send_item(it);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct = sender_pct;
        receiver_idle_pct <= receiver_pct;
    endtask

    // mostly a small set of senders so history hits, evictions, repeats and a full table occur
    task automatic send_random_traffic(input int count, input bit with_stall);
        item_t it;
        int    k;
        int    pick;
        for (int n = 0; n < count; n++) begin
            if (with_stall && n == count / 2)
                stall_requests <= stall_requests + 1;
            k = $urandom_range(0, POOL_SIZE - 1);
            it.mode = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 99) < 15)
                it.node_address = ADDR_W'($urandom());
            else
                it.node_address = node_pool[k];
            if ($urandom_range(0, 99) < 30)
                it.sequence_number = last_seq[k];
            else
                it.sequence_number = SEQ_W'($urandom());
            pick = $urandom_range(0, 99);
            if (pick < 40)
                it.msg_code = ack_now;
            else if (pick < 60)
                it.msg_code = remove_now;
            else
                it.msg_code = CODE_W'($urandom());
            if (!it.mode && it.node_address == node_pool[k])
                last_seq[k] = it.sequence_number;
            send_item(it);
        end
    endtask

    initial
    begin
        node_pool[0] = 16'h0000;
        node_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            node_pool[i] = ADDR_W'($urandom());
        for (int i = 0; i < POOL_SIZE; i++)
            last_seq[i] = SEQ_W'($urandom());

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(28, 85);
        set_codes(8'd1, 8'd2);

        // directed: adds, repeats, refused adds, removes of absent nodes, full table
        send_fields(1'b0, 16'h0000, 8'h00, 8'd1);
        send_fields(1'b0, 16'h0000, 8'h00, 8'd1);
        send_fields(1'b0, 16'hFFFF, 8'hFF, 8'd1);
        send_fields(1'b0, 16'hFFFF, 8'hFE, 8'd1);
        send_fields(1'b1, 16'h1234, 8'hFF, 8'hFF);
        send_fields(1'b0, 16'h1234, 8'h80, 8'd2);
        send_fields(1'b0, 16'h5555, 8'hAA, 8'h55);
        for (int i = 1; i <= 6; i++)
            send_fields(1'b0, ADDR_W'(16'h0101 * i), 8'(i), 8'd1);
        send_fields(1'b0, 16'hA5A5, 8'h07, 8'd1);
        send_fields(1'b1, 16'h0303, 8'h00, 8'h00);
        // 0x0000 has left the history by now, so the same sequence is new again
        send_fields(1'b0, 16'h0000, 8'h00, 8'd1);
        send_fields(1'b0, 16'h0000, 8'h00, 8'd1);
        send_fields(1'b0, 16'h0000, 8'h01, 8'd2);
        send_fields(1'b1, 16'h0000, 8'h5A, 8'hA5);
        send_fields(1'b0, 16'h0606, 8'h06, 8'd2);
        send_fields(1'b0, 16'h0606, 8'h07, 8'h00);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_codes(8'(ack_plan[p]), 8'(remove_plan[p]));
            case (p / 2)
                0: set_idling(28, 85);
                1: set_idling(85, 28);
                default: set_idling(0, 0);
            endcase
            send_random_traffic(PHASE_ITEMS, (p == 0 || p == 4));
        end

        drain();
        repeat (SETTLE_TIME) @(negedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
